### hw/rtl/rsti_pkg.sv
package rsti_pkg;

  localparam int IDX_W = 31;
  localparam int CNT_IN_W = 6;
  localparam int ERR_W = 8;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_FAN  = 2'd0,
    MODE_EQ   = 2'd1,
    MODE_UNEQ = 2'd2
  } mode_t;

  localparam logic REQ_STITCH = 1'b0;
  localparam logic REQ_FAN    = 1'b1;

  typedef struct packed {
    logic                req_type;
    idx_t                first_begin;
    logic [CNT_IN_W-1:0] first_count;
    idx_t                second_begin;
    logic [CNT_IN_W-1:0] second_count;
  } in_item_t;

  typedef struct packed {
    idx_t vert_a;
    idx_t vert_b;
    idx_t vert_c;
    logic last_tri;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

### hw/rtl/rsti_ctrl.sv
module rsti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rsti_pkg::dp_stat_t stat,
  output rsti_pkg::dp_cmd_t  cmd
);
  import rsti_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        busy = !rst_n;
        if (start && rst_n) begin
          cmd.load = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        busy = 1'b1;
        cmd.step = 1'b1;
        if (stat.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/rsti_datapath.sv
module rsti_datapath #(
  parameter int MAX_STRIP_POINTS = 33
) (
  input  logic                clk,
  input  rsti_pkg::dp_cmd_t   cmd,
  input  rsti_pkg::in_item_t  in_req,
  output rsti_pkg::out_item_t tri_item,
  output rsti_pkg::dp_stat_t  stat
);
  import rsti_pkg::*;

  localparam int CW = $clog2(MAX_STRIP_POINTS + 1);

  function automatic logic [CW-1:0] sat_count(input logic [CNT_IN_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < 2) begin
      vi = 2;
    end else if (vi > MAX_STRIP_POINTS) begin
      vi = MAX_STRIP_POINTS;
    end
    return CW'(vi);
  endfunction

  mode_t                    mode_r, mode_nxt;
  logic                     flip_r, flip_nxt;
  idx_t                     s_r, s_nxt;
  idx_t                     t_r, t_nxt;
  idx_t                     ring_r, ring_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            qc_r, qc_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     phase_r, phase_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;

  logic [CW-1:0]            fc, sc;
  logic                     fc_lt;
  logic signed [ERR_W:0]    err_sum;
  logic                     take;
  idx_t                     va, vb, vc;
  logic                     last;

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    flip_r  <= flip_nxt;
    s_r     <= s_nxt;
    t_r     <= t_nxt;
    ring_r  <= ring_nxt;
    cnt_r   <= cnt_nxt;
    qc_r    <= qc_nxt;
    idx_r   <= idx_nxt;
    phase_r <= phase_nxt;
    err_r   <= err_nxt;
  end

  assign fc = sat_count(in_req.first_count);
  assign sc = sat_count(in_req.second_count);
  assign fc_lt = fc < sc;

  // The accumulator share reaches one half when twice the error reaches the long count.
  assign err_sum = {err_r[ERR_W-1], err_r} + $signed({{(ERR_W+1-CW){1'b0}}, qc_r});
  assign take = $signed({err_sum[ERR_W-1:0], 1'b0}) >=
                $signed({{(ERR_W+1-CW){1'b0}}, cnt_r});

  always_comb begin
    mode_nxt  = mode_r;
    flip_nxt  = flip_r;
    s_nxt     = s_r;
    t_nxt     = t_r;
    ring_nxt  = ring_r;
    cnt_nxt   = cnt_r;
    qc_nxt    = qc_r;
    idx_nxt   = idx_r;
    phase_nxt = phase_r;
    err_nxt   = err_r;
    va = s_r;
    vb = t_r;
    vc = s_r + 1'b1;
    last = 1'b0;

    unique case (mode_r)
      MODE_FAN: begin
        if (idx_r == cnt_r - 1'b1) begin
          vc = ring_r;
          last = 1'b1;
        end
        if (cmd.step) begin
          s_nxt = s_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      MODE_EQ: begin
        if (!phase_r) begin
          vb = t_r + 1'b1;
        end else begin
          vb = t_r;
          vc = t_r + 1'b1;
          last = idx_r == cnt_r - 2'd2;
        end
        if (cmd.step) begin
          phase_nxt = !phase_r;
          if (phase_r) begin
            s_nxt = s_r + 1'b1;
            t_nxt = t_r + 1'b1;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      MODE_UNEQ: begin
        if (!phase_r) begin
          last = (idx_r == cnt_r - 2'd2) && !take;
          if (cmd.step) begin
            s_nxt = s_r + 1'b1;
            if (take) begin
              err_nxt = ERR_W'(err_sum - $signed({{(ERR_W+1-CW){1'b0}}, cnt_r}));
              phase_nxt = 1'b1;
            end else begin
              err_nxt = err_sum[ERR_W-1:0];
              idx_nxt = idx_r + 1'b1;
            end
          end
        end else begin
          // The long strip has already moved on, so this triangle uses the new long index.
          vc = t_r + 1'b1;
          last = idx_r == cnt_r - 2'd2;
          if (cmd.step) begin
            t_nxt = t_r + 1'b1;
            phase_nxt = 1'b0;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        last = 1'b1;
      end
    endcase

    if (cmd.load) begin
      idx_nxt = '0;
      phase_nxt = 1'b0;
      err_nxt = '0;
      ring_nxt = in_req.first_begin;
      flip_nxt = (in_req.req_type == REQ_STITCH) && fc_lt;
      if (in_req.req_type == REQ_FAN) begin
        mode_nxt = MODE_FAN;
        cnt_nxt = fc;
        qc_nxt = fc;
        s_nxt = in_req.first_begin;
        t_nxt = in_req.second_begin;
      end else if (fc == sc) begin
        mode_nxt = MODE_EQ;
        cnt_nxt = fc;
        qc_nxt = sc;
        s_nxt = in_req.first_begin;
        t_nxt = in_req.second_begin;
      end else begin
        mode_nxt = MODE_UNEQ;
        cnt_nxt = fc_lt ? sc : fc;
        qc_nxt = fc_lt ? fc : sc;
        s_nxt = fc_lt ? in_req.second_begin : in_req.first_begin;
        t_nxt = fc_lt ? in_req.first_begin : in_req.second_begin;
      end
    end
  end

  always_comb begin
    tri_item.vert_a = flip_r ? vb : va;
    tri_item.vert_b = flip_r ? va : vb;
    tri_item.vert_c = vc;
    tri_item.last_tri = last;
    stat.last = last;
  end

endmodule

### hw/rtl/ring_strip_triangle_indexer.sv
// The accepting edge loads the datapath; the first triangle is computed in the run state and registered
// at the outputs. Throughput: one triangle per cycle; a request producing N triangles (2 to 64)
// keeps busy high while they are emitted, so the next request is taken only after its last triangle.
// The rate is set by the single index sequencer, which emits one triangle a step.
// Reset (synchronous, active low) returns the controller to idle, drops out_valid
// and holds busy high. Results are strobed for one cycle each; the receiver cannot stall them.
module ring_strip_triangle_indexer #(
  parameter int MAX_STRIP_POINTS = 33
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rsti_pkg::in_item_t  in_req,
  output logic                out_valid,
  output rsti_pkg::out_item_t out_item
);
  import rsti_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  out_item_t tri_item;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  rsti_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  rsti_datapath #(
    .MAX_STRIP_POINTS (MAX_STRIP_POINTS)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .in_req   (in_req),
    .tri_item (tri_item),
    .stat     (stat)
  );

  assign out_valid_nxt = cmd.step;
  assign out_item_nxt = cmd.step ? tri_item : out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item = out_item_r;

endmodule

### sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsti_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 127;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS = 100;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t first_tri;
  } req_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_req;
  logic      out_valid;
  out_item_t out_item;

  out_item_t pending_tris[$];
  req_row_t  req_table[$];
  int        accepted_reqs;
  int        mismatch_count;
  int        cycle_count;
  bit        typed_pending;
  out_item_t typed_tri;

  ring_strip_triangle_indexer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_count(input logic [CNT_IN_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v < 2) return 2;
    if (v > 33) return 33;
    return v;
  endfunction

  function automatic void push_tri(input idx_t a, input idx_t b, input idx_t c, input bit flip);
    out_item_t tri_item;
    tri_item.vert_a   = flip ? b : a;
    tri_item.vert_b   = flip ? a : b;
    tri_item.vert_c   = c;
    tri_item.last_tri = 1'b0;
    pending_tris = {pending_tris, tri_item};
  endfunction

  // Appends every triangle that one request emits, in order.
  function automatic void build_triangles(input in_item_t req);
    idx_t      fb, sb, ps, qs, s, t, s0, t0;
    int        fc, sc, pc, qc, err, i;
    bit        flip;
    out_item_t tail;
    fb = req.first_begin;
    sb = req.second_begin;
    fc = clamp_count(req.first_count);
    sc = clamp_count(req.second_count);
    if (req.req_type == REQ_FAN) begin
      for (i = 1; i < fc; i++)
        push_tri(idx_t'(fb + i - 1), sb, idx_t'(fb + i), 1'b0);
      push_tri(idx_t'(fb + fc - 1), sb, fb, 1'b0);
    end else if (fc == sc) begin
      for (i = 0; i + 1 < fc; i++) begin
        push_tri(idx_t'(fb + i), idx_t'(sb + i + 1), idx_t'(fb + i + 1), 1'b0);
        push_tri(idx_t'(fb + i), idx_t'(sb + i), idx_t'(sb + i + 1), 1'b0);
      end
    end else begin
      // The longer strip sets the pace; the shorter one advances when its
      // accumulated share reaches one half.
      flip = (fc < sc);
      ps = flip ? sb : fb;
      pc = flip ? sc : fc;
      qs = flip ? fb : sb;
      qc = flip ? fc : sc;
      s = ps;
      t = qs;
      err = 0;
      for (i = 0; i + 1 < pc; i++) begin
        s0 = s;
        s = s + 1'b1;
        push_tri(s0, t, s, flip);
        err += qc;
        if (2 * err >= pc) begin
          t0 = t;
          err -= pc;
          t = t + 1'b1;
          push_tri(s, t0, t, flip);
        end
      end
    end
    tail = pending_tris.pop_back();
    tail.last_tri = 1'b1;
    pending_tris = {pending_tris, tail};
  endfunction

  function automatic in_item_t make_req(input logic kind, input idx_t fb,
                                        input logic [CNT_IN_W-1:0] fc,
                                        input idx_t sb, input logic [CNT_IN_W-1:0] sc);
    in_item_t req;
    req.req_type     = kind;
    req.first_begin  = fb;
    req.first_count  = fc;
    req.second_begin = sb;
    req.second_count = sc;
    return req;
  endfunction

  function automatic void add_row(input logic kind, input idx_t fb,
                                  input logic [CNT_IN_W-1:0] fc, input idx_t sb,
                                  input logic [CNT_IN_W-1:0] sc, input bit typed,
                                  input idx_t a, input idx_t b, input idx_t c);
    req_row_t row;
    row.req                = make_req(kind, fb, fc, sb, sc);
    row.typed              = typed;
    row.first_tri.vert_a   = a;
    row.first_tri.vert_b   = b;
    row.first_tri.vert_c   = c;
    row.first_tri.last_tri = 1'b0;
    req_table = {req_table, row};
  endfunction

  function automatic logic [CNT_IN_W-1:0] random_count();
    if ($urandom_range(7, 0) == 0) return CNT_IN_W'($urandom_range(63, 0));
    return CNT_IN_W'($urandom_range(33, 2));
  endfunction

  function automatic idx_t random_index();
    if ($urandom_range(7, 0) == 0) return idx_t'(31'h7FFF_FFFF - $urandom_range(40, 0));
    return idx_t'($urandom);
  endfunction

  function automatic in_item_t random_req();
    in_item_t req;
    req = make_req(1'($urandom_range(1, 0)), random_index(), random_count(),
                   random_index(), random_count());
    if (req.req_type == REQ_STITCH && $urandom_range(3, 0) == 0)
      req.second_count = req.first_count;
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // With gaps, start drops at random in any cycle, busy or not.
  task automatic send_req(input in_item_t req, input bit gaps);
    int seen;
    seen = accepted_reqs;
    while (accepted_reqs == seen) begin
      if (gaps && $urandom_range(99, 0) < 24) begin
        start  <= 1'b0;
        in_req <= random_req();
      end else begin
        start  <= 1'b1;
        in_req <= req;
      end
      @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    int first_idx;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (pending_tris.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected triangle a=%h b=%h c=%h last=%b", $time,
                   out_item.vert_a, out_item.vert_b, out_item.vert_c, out_item.last_tri);
      end else begin
        if (out_item !== pending_tris[0]) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: expected a=%h b=%h c=%h last=%b, got a=%h b=%h c=%h last=%b",
                     $time, pending_tris[0].vert_a, pending_tris[0].vert_b,
                     pending_tris[0].vert_c, pending_tris[0].last_tri,
                     out_item.vert_a, out_item.vert_b, out_item.vert_c, out_item.last_tri);
        end
        void'(pending_tris.pop_front());
      end
    end
    if (rst_n && start && !busy) begin
      first_idx = pending_tris.size();
      build_triangles(in_req);
      if (typed_pending) pending_tris[first_idx] = typed_tri;
      accepted_reqs++;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_req         = '0;
    accepted_reqs  = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    typed_pending  = 1'b0;
    typed_tri      = '0;

    // Fans: smallest ring, saturated counts, index wrap.
    add_row(REQ_FAN,    31'd0,           6'd2,  31'd5,           6'd9,  1'b1,
            31'd0, 31'd5, 31'd1);
    add_row(REQ_FAN,    31'd10,          6'd0,  31'd3,           6'd0,  1'b1,
            31'd10, 31'd3, 31'd11);
    add_row(REQ_FAN,    31'd200,         6'd1,  31'd7,           6'd63, 1'b0, '0, '0, '0);
    add_row(REQ_FAN,    31'd1000,        6'd33, 31'd999,         6'd2,  1'b0, '0, '0, '0);
    add_row(REQ_FAN,    31'h7FFF_FFF0,   6'd63, 31'h1234,        6'd33, 1'b1,
            31'h7FFF_FFF0, 31'h1234, 31'h7FFF_FFF1);
    add_row(REQ_FAN,    31'h7FFF_FFFF,   6'd2,  31'h7FFF_FFFF,   6'd2,  1'b1,
            31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    // Stitch with equal counts, including counts that saturate to equal.
    add_row(REQ_STITCH, 31'd0,           6'd2,  31'd100,         6'd2,  1'b1,
            31'd0, 31'd101, 31'd1);
    add_row(REQ_STITCH, 31'd50,          6'd33, 31'd500,         6'd33, 1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h7FFF_FFFF,   6'd63, 31'd0,           6'd63, 1'b1,
            31'h7FFF_FFFF, 31'd1, 31'd0);
    add_row(REQ_STITCH, 31'd20,          6'd0,  31'd40,          6'd1,  1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h7FFF_FFFE,   6'd4,  31'h7FFF_FFFF,   6'd4,  1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'd3,           6'd40, 31'd300,         6'd34, 1'b0, '0, '0, '0);
    // Unequal counts, each strip as the longer one; the swapped cases flip winding. A last fan follows.
    add_row(REQ_STITCH, 31'd0,           6'd3,  31'd10,          6'd2,  1'b1,
            31'd0, 31'd10, 31'd1);
    add_row(REQ_STITCH, 31'd0,           6'd2,  31'd10,          6'd3,  1'b1,
            31'd0, 31'd10, 31'd11);
    add_row(REQ_STITCH, 31'd100,         6'd33, 31'd200,         6'd2,  1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'd100,         6'd2,  31'd200,         6'd33, 1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'd7,           6'd33, 31'd70,          6'd32, 1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'd7,           6'd32, 31'd70,          6'd33, 1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h2AAA_AAAA,   6'd17, 31'h5555_5555,   6'd5,  1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h5555_5555,   6'd5,  31'h2AAA_AAAA,   6'd17, 1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h7FFF_FFFF,   6'd63, 31'h7FFF_FFF0,   6'd0,  1'b0, '0, '0, '0);
    add_row(REQ_STITCH, 31'h7FFF_FFF8,   6'd0,  31'h7FFF_FFFA,   6'd63, 1'b0, '0, '0, '0);
    add_row(REQ_FAN,    31'h2AAA_AAAA,   6'd21, 31'h5555_5555,   6'd42, 1'b0, '0, '0, '0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (req_table[k]) begin
      typed_pending = req_table[k].typed;
      typed_tri     = req_table[k].first_tri;
      send_req(req_table[k].req, 1'b1);
    end
    typed_pending = 1'b0;

    // A stretch in the middle runs back to back with no gaps at all.
    for (n = 0; n < RANDOM_REQS; n++)
      send_req(random_req(), !(n >= 50 && n < 90));
    start <= 1'b0;

    while (pending_tris.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_tris.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
